// ===== sv/lkv_pkg.sv =====
`default_nettype none
package lkv_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int KEY_W = 32;
  localparam int VAL_W = 22;
  localparam int STAMP_W = 32;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [2:0] {
    ST_MISS     = 3'd0,
    ST_HIT      = 3'd1,
    ST_DEAD     = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_INSERTED = 3'd4,
    ST_EVICTED  = 3'd5,
    ST_REJECTED = 3'd6
  } status_t;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_STORE  = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                 req_type;
    logic [KEY_W-1:0]     cache_key;
    logic [VAL_W-1:0]     value_in;
    logic                 alive_flag;
    logic [STAMP_W-1:0]   now_time;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [VAL_W-1:0]       value_out;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

  // search record that walks the cell row
  typedef struct packed {
    logic                 vld;
    logic [KEY_W-1:0]     key;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [VAL_W-1:0]     hit_val;
    logic                 free;
    logic [IDX_W-1:0]     free_idx;
    logic                 old;
    logic [IDX_W-1:0]     old_idx;
    logic [STAMP_W-1:0]   old_stamp;
  } scan_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_TOUCH,
    CMD_UPDATE,
    CMD_FILL,
    CMD_KILL
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [IDX_W-1:0]     idx;
    logic [KEY_W-1:0]     key;
    logic [VAL_W-1:0]     value;
    logic [STAMP_W-1:0]   stamp;
  } wr_t;

  // wrap-safe: a is older than b
  function automatic logic stamp_before(input logic [STAMP_W-1:0] a,
                                        input logic [STAMP_W-1:0] b);
    logic [STAMP_W-1:0] diff;
    diff = a - b;
    return diff[STAMP_W-1];
  endfunction

endpackage
`default_nettype wire

// ===== sv/lkv_cell.sv =====
`default_nettype none
module lkv_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [lkv_pkg::IDX_W-1:0] cell_idx,
  input  wire lkv_pkg::scan_t            rec_in,
  input  wire lkv_pkg::wr_t              wr,
  output lkv_pkg::scan_t                 rec_out
);

  logic                        valid;
  logic [lkv_pkg::KEY_W-1:0]   key;
  logic [lkv_pkg::VAL_W-1:0]   value;
  logic [lkv_pkg::STAMP_W-1:0] stamp;
  lkv_pkg::scan_t              rec_next;
  logic                        sel;

  assign sel = (wr.cmd != lkv_pkg::CMD_NONE) && (wr.idx == cell_idx);

  always_comb begin
    rec_next = rec_in;
    if (valid) begin
      if (!rec_in.hit && key == rec_in.key) begin
        rec_next.hit     = 1'b1;
        rec_next.hit_idx = cell_idx;
        rec_next.hit_val = value;
      end
      // strict compare keeps ties on the lowest slot
      if (!rec_in.old || lkv_pkg::stamp_before(stamp, rec_in.old_stamp)) begin
        rec_next.old       = 1'b1;
        rec_next.old_idx   = cell_idx;
        rec_next.old_stamp = stamp;
      end
    end else if (!rec_in.free) begin
      rec_next.free     = 1'b1;
      rec_next.free_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    rec_out <= rec_next;
    if (rst) begin
      rec_out.vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      unique case (wr.cmd)
        lkv_pkg::CMD_TOUCH: begin
          stamp <= wr.stamp;
        end
        lkv_pkg::CMD_UPDATE: begin
          value <= wr.value;
          stamp <= wr.stamp;
        end
        lkv_pkg::CMD_FILL: begin
          key   <= wr.key;
          value <= wr.value;
          stamp <= wr.stamp;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      unique case (wr.cmd)
        lkv_pkg::CMD_FILL: valid <= 1'b1;
        lkv_pkg::CMD_KILL: valid <= 1'b0;
        default: valid <= valid;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/lkv_ctrl.sv =====
`default_nettype none
module lkv_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire lkv_pkg::req_t  req,
  output logic                done,
  output lkv_pkg::rsp_t       rsp,
  output lkv_pkg::scan_t      head,
  input  wire lkv_pkg::scan_t tail,
  output lkv_pkg::wr_t        wr
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  state_t                      state;
  lkv_pkg::req_t               cur;
  logic [lkv_pkg::CNT_W-1:0]   count;
  logic [lkv_pkg::CNT_W-1:0]   count_next;
  lkv_pkg::status_t            status_next;
  logic [lkv_pkg::VAL_W-1:0]   vout_next;
  lkv_pkg::wr_t                wr_next;
  logic                        accept;

  assign busy   = (state == S_SCAN);
  assign accept = start && !busy;

  always_comb begin
    status_next   = lkv_pkg::ST_MISS;
    vout_next     = '0;
    count_next    = count;
    wr_next.cmd   = lkv_pkg::CMD_NONE;
    wr_next.idx   = tail.hit_idx;
    wr_next.key   = cur.cache_key;
    wr_next.value = cur.value_in;
    wr_next.stamp = cur.now_time;
    if (cur.req_type == lkv_pkg::REQ_LOOKUP) begin
      if (cur.cache_key != '0 && tail.hit) begin
        if (cur.alive_flag) begin
          status_next = lkv_pkg::ST_HIT;
          vout_next   = tail.hit_val;
          wr_next.cmd = lkv_pkg::CMD_TOUCH;
        end else begin
          status_next = lkv_pkg::ST_DEAD;
          wr_next.cmd = lkv_pkg::CMD_KILL;
          count_next  = count - 1'b1;
        end
      end
    end else begin
      priority if (cur.cache_key == '0 || cur.value_in == '0 || !cur.alive_flag) begin
        status_next = lkv_pkg::ST_REJECTED;
      end else if (tail.hit) begin
        status_next = lkv_pkg::ST_UPDATED;
        wr_next.cmd = lkv_pkg::CMD_UPDATE;
      end else if (tail.free) begin
        status_next = lkv_pkg::ST_INSERTED;
        wr_next.cmd = lkv_pkg::CMD_FILL;
        wr_next.idx = tail.free_idx;
        count_next  = count + 1'b1;
      end else begin
        // full: the evicted slot is the only one free, so refill it in place
        status_next = lkv_pkg::ST_EVICTED;
        wr_next.cmd = lkv_pkg::CMD_FILL;
        wr_next.idx = tail.old_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    head.vld <= 1'b0;
    done     <= 1'b0;
    wr.cmd   <= lkv_pkg::CMD_NONE;
    if (accept) begin
      cur            <= req;
      head.vld       <= 1'b1;
      head.key       <= req.cache_key;
      head.hit       <= 1'b0;
      head.hit_idx   <= '0;
      head.hit_val   <= '0;
      head.free      <= 1'b0;
      head.free_idx  <= '0;
      head.old       <= 1'b0;
      head.old_idx   <= '0;
      head.old_stamp <= '0;
    end
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      head.vld <= 1'b0;
      done     <= 1'b0;
      wr.cmd   <= lkv_pkg::CMD_NONE;
    end else begin
      unique case (state)
        S_IDLE, S_WRITE: begin
          if (accept) begin
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (tail.vld) begin
            state           <= S_WRITE;
            done            <= 1'b1;
            rsp.status      <= status_next;
            rsp.value_out   <= vout_next;
            rsp.entry_count <= lkv_pkg::COUNT_OUT_W'(count_next);
            count           <= count_next;
            wr.cmd          <= wr_next.cmd;
            wr.idx          <= wr_next.idx;
            wr.key          <= wr_next.key;
            wr.value        <= wr_next.value;
            wr.stamp        <= wr_next.stamp;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/lru_key_value_cache_top.sv =====
`default_nettype none
// LRU key/value cache, fully associative, ENTRIES slots in a row of cells.
// Request channel: drive req and raise start; the item is taken at a rising
// edge where start is high and busy is low. A lookup (req_type 0) returns the
// stored value and refreshes the slot's stamp, or removes the slot when
// alive_flag is low. A store (req_type 1) updates a matching key, fills the
// lowest free slot, or evicts the slot with the oldest stamp when full.
// Response channel: rsp is valid for exactly one cycle while done is high;
// there is no backpressure, so the receiver must take it in that cycle.
// Timing: a search record walks the cell row one slot per cycle, registered in
// the head register and then in each cell; done is registered from the tail.
// The slot write lands on the edge that ends the done cycle, and busy is low
// then (it is high only during the search), so the next item can be taken then.
// Reset (synchronous rst) clears all slot valid bits and the entry count at
// once; no clearing pass is needed and a request can follow the next cycle.
module lru_key_value_cache_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire lkv_pkg::req_t req,
  output logic               done,
  output lkv_pkg::rsp_t      rsp
);

  lkv_pkg::scan_t chain [lkv_pkg::ENTRIES+1];
  lkv_pkg::wr_t   wr;

  lkv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp),
    .head  (chain[0]),
    .tail  (chain[lkv_pkg::ENTRIES]),
    .wr    (wr)
  );

  for (genvar i = 0; i < lkv_pkg::ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (lkv_pkg::IDX_W'(i)),
      .rec_in   (chain[i]),
      .wr       (wr),
      .rec_out  (chain[i+1])
    );
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepting an item");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_value_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != lkv_pkg::ST_HIT |-> rsp.value_out == '0)
    else $error("value returned without a hit");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status == lkv_pkg::ST_INSERTED || rsp.status == lkv_pkg::ST_EVICTED)
    |-> rsp.entry_count != '0)
    else $error("empty cache after an insert");
`endif

endmodule
`default_nettype wire

// ===== sim/lru_cache_checker.sv =====
`timescale 1ns / 100ps

module lru_cache_checker
  import lkv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire logic  busy,
  input  wire req_t  req,
  input  wire logic  done,
  input  wire rsp_t  rsp,
  output int         errors,
  output int         pending
);

  logic               slot_used  [ENTRIES];
  logic [KEY_W-1:0]   slot_tag   [ENTRIES];
  logic [VAL_W-1:0]   slot_data  [ENTRIES];
  logic [STAMP_W-1:0] slot_touch [ENTRIES];
  int unsigned        used_count;
  int                 err_count = 0;

  rsp_t pending_results[$];

  assign errors  = err_count;
  assign pending = pending_results.size();

  task automatic flag_mismatch(input string field, input int got, input int want);
    $display("%0t: %s got %0d, want %0d", $realtime, field, got, want);
    err_count++;
  endtask

  // a is strictly older than b, modulo 2^32
  function automatic logic older_than(input logic [STAMP_W-1:0] a,
                                      input logic [STAMP_W-1:0] b);
    logic [STAMP_W-1:0] diff;
    diff = a - b;
    return diff[STAMP_W-1];
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < ENTRIES; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic rsp_t predict_cache_access(input req_t r);
    rsp_t res;
    int   hit_at;
    int   free_at;
    int   victim;
    res.status    = ST_MISS;
    res.value_out = '0;
    hit_at = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit_at < 0 && slot_used[i] && slot_tag[i] == r.cache_key) hit_at = i;

    if (r.req_type == REQ_LOOKUP) begin
      if (r.cache_key != '0 && hit_at >= 0) begin
        if (!r.alive_flag) begin
          slot_used[hit_at] = 1'b0;
          used_count--;
          res.status = ST_DEAD;
        end else begin
          slot_touch[hit_at] = r.now_time;
          res.value_out = slot_data[hit_at];
          res.status = ST_HIT;
        end
      end
    end else if (r.cache_key == '0 || r.value_in == '0 || !r.alive_flag) begin
      res.status = ST_REJECTED;
    end else if (hit_at >= 0) begin
      slot_data[hit_at]  = r.value_in;
      slot_touch[hit_at] = r.now_time;
      res.status = ST_UPDATED;
    end else begin
      res.status = ST_INSERTED;
      free_at = first_free_slot();
      if (free_at < 0) begin
        // evict the oldest stamp, ties to the lowest slot
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (slot_used[i] && (victim < 0 || older_than(slot_touch[i], slot_touch[victim])))
            victim = i;
        slot_used[victim] = 1'b0;
        used_count--;
        res.status = ST_EVICTED;
        free_at = first_free_slot();
      end
      slot_used[free_at]  = 1'b1;
      slot_tag[free_at]   = r.cache_key;
      slot_data[free_at]  = r.value_in;
      slot_touch[free_at] = r.now_time;
      used_count++;
    end
    res.entry_count = used_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      used_count = 0;
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("items outstanding at result", 0, 1);
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch("status", int'(rsp.status), int'(want.status));
          if (rsp.value_out !== want.value_out)
            flag_mismatch("value_out", int'(rsp.value_out), int'(want.value_out));
          if (rsp.entry_count !== want.entry_count)
            flag_mismatch("entry_count", int'(rsp.entry_count), int'(want.entry_count));
        end
      end
      if (start && !busy)
        pending_results.push_back(predict_cache_access(req));
    end
  end

endmodule

// ===== sim/lru_key_value_cache_top_tb.sv =====
`timescale 1ns / 100ps

module lru_key_value_cache_top_tb;
  import lkv_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int POOL_SIZE  = 128;

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;
  int   errors;
  int   pending;

  lru_key_value_cache_top dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  lru_cache_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("lru_key_value_cache_top: mismatch");
        $finish;
      end
    end
  end

  logic [KEY_W-1:0]   key_pool [POOL_SIZE];
  logic [STAMP_W-1:0] tick;
  int                 burst_left = 0;

  function automatic req_t make_item(input logic kind, input logic [KEY_W-1:0] key,
                                     input logic [VAL_W-1:0] value, input logic alive,
                                     input logic [STAMP_W-1:0] now);
    req_t r;
    r.req_type   = kind;
    r.cache_key  = key;
    r.value_in   = value;
    r.alive_flag = alive;
    r.now_time   = now;
    return r;
  endfunction

  // hold the item until taken; idle for a random gap, possibly none, between bursts
  task automatic send_item(input req_t item);
    int gap;
    req   <= item;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic random_phase(input int count, input int pool, input int store_pct,
                              input int max_step, input bit jumps);
    req_t        r;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      tick = tick + $urandom_range(0, max_step);
      if (jumps && $urandom_range(0, 15) == 0) tick = $urandom;
      r.now_time = tick;
      r.req_type = ($urandom_range(0, 99) < store_pct) ? REQ_STORE : REQ_LOOKUP;
      pick = $urandom_range(0, 19);
      if (pick == 0)      r.cache_key = '0;
      else if (pick == 1) r.cache_key = $urandom;
      else                r.cache_key = key_pool[$urandom_range(0, pool - 1)];
      r.value_in = VAL_W'($urandom);
      if (r.req_type == REQ_STORE) begin
        if ($urandom_range(0, 19) == 0) r.value_in = '0;
        else if (r.value_in == '0) r.value_in = VAL_W'(1);
        r.alive_flag = ($urandom_range(0, 19) != 0);
      end else begin
        r.alive_flag = ($urandom_range(0, 9) != 0);
      end
      send_item(r);
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == '0) key_pool[i] = 1;
    end
    key_pool[0] = '1;
    key_pool[1] = 32'h8000_0000;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero key, empty cache, every reject reason, stamps across the wrap
    send_item(make_item(REQ_LOOKUP, '0, '0, 1'b1, '0));
    send_item(make_item(REQ_LOOKUP, 32'd5, 22'd7, 1'b1, 32'd1));
    send_item(make_item(REQ_STORE, '0, 22'd9, 1'b1, 32'd2));
    send_item(make_item(REQ_STORE, 32'd9, '0, 1'b1, 32'd3));
    send_item(make_item(REQ_STORE, 32'd9, 22'd9, 1'b0, 32'd4));
    send_item(make_item(REQ_STORE, '1, '1, 1'b1, 32'hFFFF_FFF0));
    send_item(make_item(REQ_STORE, 32'd1, 22'd1, 1'b1, '1));
    send_item(make_item(REQ_LOOKUP, '1, '0, 1'b1, '0));
    send_item(make_item(REQ_STORE, 32'd1, 22'h2A_AAAA, 1'b1, 32'd5));
    send_item(make_item(REQ_LOOKUP, 32'd1, 22'h15_5555, 1'b1, 32'd6));
    send_item(make_item(REQ_LOOKUP, 32'd1, '0, 1'b0, 32'd7));
    send_item(make_item(REQ_LOOKUP, 32'd1, '0, 1'b1, 32'd8));
    send_item(make_item(REQ_LOOKUP, '0, '1, 1'b0, '1));
    send_item(make_item(REQ_STORE, 32'h8000_0000, 22'h15_5555, 1'b1, 32'h8000_0000));
    send_item(make_item(REQ_STORE, 32'h8000_0000, '1, 1'b1, 32'h7FFF_FFFF));
    send_item(make_item(REQ_LOOKUP, 32'h8000_0000, '0, 1'b1, 32'h8000_0001));
    send_item(make_item(REQ_LOOKUP, 32'h1234_5678, '1, 1'b0, 32'h8000_0002));
    send_item(make_item(REQ_STORE, 32'h5555_5555, 22'h2A_AAAA, 1'b0, '0));

    tick = 32'hFFFF_FF00;
    // fill fast with mostly equal stamps, then churn across the wrap
    random_phase(300, 96, 75, 1, 1'b0);
    random_phase(400, 80, 50, 40, 1'b0);
    random_phase(300, 48, 30, 8, 1'b0);
    random_phase(200, POOL_SIZE, 60, 1000, 1'b1);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("lru_key_value_cache_top: match");
    end else begin
      $display("lru_key_value_cache_top: mismatch");
    end
    $finish;
  end

endmodule
